// ===== src/qtrs_pkg.sv =====
// Package for the quaternion TRS world matrix core: field widths, internal
// widths and the round-and-saturate helper. No dependencies.
package qtrs_pkg;

    localparam int QUAT_W  = 16;
    localparam int SCALE_W = 16;
    localparam int TRANS_W = 32;
    localparam int OUT_W   = 32;

    localparam int PP_W    = 2 * QUAT_W;
    localparam int ENT_W   = PP_W + 3;
    localparam int PROD_W  = ENT_W + SCALE_W;
    localparam int FRAC_SH = 20;
    localparam int RND_W   = PROD_W + 1;
    localparam int SHR_W   = RND_W - FRAC_SH;

    localparam logic signed [ENT_W-1:0] ONE_Q28 = ENT_W'(64'sd1 <<< 28);
    localparam logic signed [RND_W-1:0] HALF_Q36 = RND_W'(64'sd1 <<< (FRAC_SH - 1));

    localparam logic signed [SHR_W-1:0] OUT_MAX =
        SHR_W'({1'b0, {(OUT_W-1){1'b1}}});
    localparam logic signed [SHR_W-1:0] OUT_MIN =
        -SHR_W'({1'b0, {(OUT_W-1){1'b1}}}) - SHR_W'(1);

    function automatic logic signed [OUT_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [RND_W-1:0] sum;
        logic signed [SHR_W-1:0] shr;
        logic signed [OUT_W-1:0] res;
        sum = RND_W'(p) + HALF_Q36;
        shr = SHR_W'(sum >>> FRAC_SH);
        if (shr > OUT_MAX) begin
            res = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (shr < OUT_MIN) begin
            res = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            res = OUT_W'(shr);
        end
        return res;
    endfunction

endpackage

// ===== src/quaternion_trs_world_matrix_core.sv =====
// Stages from an accepted request to o_valid: products, entries, scale multiply,
// round/saturate into the output register.
// Throughput: one request per cycle; each stage advances when the next one
// is empty or advancing, so a stall at the output back-pressures in place.
// Reset (i_rst_n, synchronous, active low) clears all stage valid bits only.
// Top level of the quaternion TRS world matrix core; uses qtrs_pkg.
module quaternion_trs_world_matrix_core import qtrs_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [QUAT_W-1:0]  i_quat_x,
    input  logic signed [QUAT_W-1:0]  i_quat_y,
    input  logic signed [QUAT_W-1:0]  i_quat_z,
    input  logic signed [QUAT_W-1:0]  i_quat_w,
    input  logic signed [SCALE_W-1:0] i_scale_x,
    input  logic signed [SCALE_W-1:0] i_scale_y,
    input  logic signed [SCALE_W-1:0] i_scale_z,
    input  logic signed [TRANS_W-1:0] i_trans_x,
    input  logic signed [TRANS_W-1:0] i_trans_y,
    input  logic signed [TRANS_W-1:0] i_trans_z,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [OUT_W-1:0]   o_m_r0_c0,
    output logic signed [OUT_W-1:0]   o_m_r0_c1,
    output logic signed [OUT_W-1:0]   o_m_r0_c2,
    output logic signed [OUT_W-1:0]   o_m_r1_c0,
    output logic signed [OUT_W-1:0]   o_m_r1_c1,
    output logic signed [OUT_W-1:0]   o_m_r1_c2,
    output logic signed [OUT_W-1:0]   o_m_r2_c0,
    output logic signed [OUT_W-1:0]   o_m_r2_c1,
    output logic signed [OUT_W-1:0]   o_m_r2_c2,
    output logic signed [TRANS_W-1:0] o_m_r3_c0,
    output logic signed [TRANS_W-1:0] o_m_r3_c1,
    output logic signed [TRANS_W-1:0] o_m_r3_c2
);

    typedef logic signed [SCALE_W-1:0] t_scale3 [3];
    typedef logic signed [TRANS_W-1:0] t_trans3 [3];

    logic r_v1, r_v2, r_v3, r_v4;
    logic adv1, adv2, adv3, adv4;

    // stage 1: quaternion products xx yy zz xy xz yz xw yw zw
    logic signed [PP_W-1:0]  r_pp [9];
    t_scale3                 r_s1;
    t_trans3                 r_t1;
    // stage 2: rotation entries in Q.28
    logic signed [ENT_W-1:0] r_e [9];
    logic signed [ENT_W-1:0] n_e [9];
    t_scale3                 r_s2;
    t_trans3                 r_t2;
    // stage 3: scaled entries in Q.36
    logic signed [PROD_W-1:0] r_p [9];
    logic signed [PROD_W-1:0] n_p [9];
    t_trans3                  r_t3;
    // stage 4: output register
    logic signed [OUT_W-1:0]  r_m [9];
    t_trans3                  r_t4;

    assign adv4    = !r_v4 || !i_stall;
    assign adv3    = !r_v3 || adv4;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_pp[0] <= i_quat_x * i_quat_x;
            r_pp[1] <= i_quat_y * i_quat_y;
            r_pp[2] <= i_quat_z * i_quat_z;
            r_pp[3] <= i_quat_x * i_quat_y;
            r_pp[4] <= i_quat_x * i_quat_z;
            r_pp[5] <= i_quat_y * i_quat_z;
            r_pp[6] <= i_quat_x * i_quat_w;
            r_pp[7] <= i_quat_y * i_quat_w;
            r_pp[8] <= i_quat_z * i_quat_w;
            r_s1    <= '{i_scale_x, i_scale_y, i_scale_z};
            r_t1    <= '{i_trans_x, i_trans_y, i_trans_z};
        end
    end

    always_comb begin
        logic signed [ENT_W-1:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
        xx = ENT_W'(r_pp[0]);
        yy = ENT_W'(r_pp[1]);
        zz = ENT_W'(r_pp[2]);
        xy = ENT_W'(r_pp[3]);
        xz = ENT_W'(r_pp[4]);
        yz = ENT_W'(r_pp[5]);
        xw = ENT_W'(r_pp[6]);
        yw = ENT_W'(r_pp[7]);
        zw = ENT_W'(r_pp[8]);
        n_e[0] = ONE_Q28 - ((yy + zz) <<< 1);
        n_e[1] = (xy + zw) <<< 1;
        n_e[2] = (xz - yw) <<< 1;
        n_e[3] = (xy - zw) <<< 1;
        n_e[4] = ONE_Q28 - ((xx + zz) <<< 1);
        n_e[5] = (yz + xw) <<< 1;
        n_e[6] = (xz + yw) <<< 1;
        n_e[7] = (yz - xw) <<< 1;
        n_e[8] = ONE_Q28 - ((xx + yy) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_e  <= n_e;
            r_s2 <= r_s1;
            r_t2 <= r_t1;
        end
    end

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n_p[i] = PROD_W'(r_e[i]) * PROD_W'(r_s2[i / 3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_p  <= n_p;
            r_t3 <= r_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            for (int i = 0; i < 9; i++) begin
                r_m[i] <= round_sat(r_p[i]);
            end
            r_t4 <= r_t3;
        end
    end

    assign o_valid   = r_v4;
    assign o_m_r0_c0 = r_m[0];
    assign o_m_r0_c1 = r_m[1];
    assign o_m_r0_c2 = r_m[2];
    assign o_m_r1_c0 = r_m[3];
    assign o_m_r1_c1 = r_m[4];
    assign o_m_r1_c2 = r_m[5];
    assign o_m_r2_c0 = r_m[6];
    assign o_m_r2_c1 = r_m[7];
    assign o_m_r2_c2 = r_m[8];
    assign o_m_r3_c0 = r_t4[0];
    assign o_m_r3_c1 = r_t4[1];
    assign o_m_r3_c2 = r_t4[2];

endmodule

// ===== dv/trs_matrix_checker.sv =====
// Watches both channels of quaternion_trs_world_matrix_core, predicts each world matrix
// from the accepted request and compares it field by field. Depends on qtrs_pkg.
module trs_matrix_checker import qtrs_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_in_stall,
    input  logic signed [QUAT_W-1:0]  i_quat_x,
    input  logic signed [QUAT_W-1:0]  i_quat_y,
    input  logic signed [QUAT_W-1:0]  i_quat_z,
    input  logic signed [QUAT_W-1:0]  i_quat_w,
    input  logic signed [SCALE_W-1:0] i_scale_x,
    input  logic signed [SCALE_W-1:0] i_scale_y,
    input  logic signed [SCALE_W-1:0] i_scale_z,
    input  logic signed [TRANS_W-1:0] i_trans_x,
    input  logic signed [TRANS_W-1:0] i_trans_y,
    input  logic signed [TRANS_W-1:0] i_trans_z,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [11:0][OUT_W-1:0]    i_matrix,
    output int                        o_mismatch_count,
    output int                        o_matrices_due
);

    typedef logic [11:0][OUT_W-1:0] t_matrix;

    t_matrix matrix_q[$];
    int      mismatches = 0;

    string field_names[12] = '{
        "m_r0_c0", "m_r0_c1", "m_r0_c2", "m_r1_c0", "m_r1_c1", "m_r1_c2",
        "m_r2_c0", "m_r2_c1", "m_r2_c2", "m_r3_c0", "m_r3_c1", "m_r3_c2"
    };

    function automatic logic [OUT_W-1:0] scale_to_q16(input longint e28, input longint s88);
        longint p;
        longint r;
        p = e28 * s88;
        r = (p + (longint'(1) <<< 19)) >>> 20;
        if (r > longint'(32'sh7fffffff)) begin
            r = longint'(32'sh7fffffff);
        end
        if (r < -longint'(32'sh7fffffff) - 1) begin
            r = -longint'(32'sh7fffffff) - 1;
        end
        return r[OUT_W-1:0];
    endfunction

    function automatic t_matrix trs_compose();
        longint  x, y, z, w, sx, sy, sz;
        longint  xx, yy, zz, xy, xz, yz, xw, yw, zw;
        longint  e[9];
        longint  one_q28;
        t_matrix m;
        x  = longint'(i_quat_x);
        y  = longint'(i_quat_y);
        z  = longint'(i_quat_z);
        w  = longint'(i_quat_w);
        sx = longint'(i_scale_x);
        sy = longint'(i_scale_y);
        sz = longint'(i_scale_z);
        one_q28 = longint'(1) <<< 28;
        xx = x * x;
        yy = y * y;
        zz = z * z;
        xy = x * y;
        xz = x * z;
        yz = y * z;
        xw = x * w;
        yw = y * w;
        zw = z * w;
        e[0] = one_q28 - 2 * (yy + zz);
        e[1] = 2 * (xy + zw);
        e[2] = 2 * (xz - yw);
        e[3] = 2 * (xy - zw);
        e[4] = one_q28 - 2 * (xx + zz);
        e[5] = 2 * (yz + xw);
        e[6] = 2 * (xz + yw);
        e[7] = 2 * (yz - xw);
        e[8] = one_q28 - 2 * (xx + yy);
        for (int c = 0; c < 3; c++) begin
            m[c]     = scale_to_q16(e[c], sx);
            m[3 + c] = scale_to_q16(e[3 + c], sy);
            m[6 + c] = scale_to_q16(e[6 + c], sz);
        end
        m[9]  = i_trans_x;
        m[10] = i_trans_y;
        m[11] = i_trans_z;
        return m;
    endfunction

    always @(posedge i_clk) begin
        t_matrix want;
        if (i_rst_n) begin
            if (i_valid && !i_in_stall) begin
                matrix_q.push_back(trs_compose());
            end
            if (i_out_valid && !i_out_stall) begin
                if (matrix_q.size() == 0) begin
                    $error("matrix returned with no request pending");
                    mismatches++;
                end else begin
                    want = matrix_q.pop_front();
                    for (int f = 0; f < 12; f++) begin
                        if (i_matrix[f] !== want[f]) begin
                            $error("%s expected %0d got %0d", field_names[f],
                                   $signed(want[f]), $signed(i_matrix[f]));
                            mismatches++;
                        end
                    end
                end
            end
        end
        o_mismatch_count <= mismatches;
        o_matrices_due   <= matrix_q.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for quaternion_trs_world_matrix_core: drives directed and random requests
// under several idle/stall mixes and reports the verdict. Uses qtrs_pkg and trs_matrix_checker.
module tb_top import qtrs_pkg::*;;

    typedef struct packed {
        logic signed [QUAT_W-1:0]  qx, qy, qz, qw;
        logic signed [SCALE_W-1:0] sx, sy, sz;
        logic signed [TRANS_W-1:0] tx, ty, tz;
    } t_request;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic signed [QUAT_W-1:0]  i_quat_x, i_quat_y, i_quat_z, i_quat_w;
    logic signed [SCALE_W-1:0] i_scale_x, i_scale_y, i_scale_z;
    logic signed [TRANS_W-1:0] i_trans_x, i_trans_y, i_trans_z;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [11:0][OUT_W-1:0] o_matrix;

    int idle_pct  = 0;
    int stall_pct = 0;
    int mismatch_count;
    int matrices_due;

    always #1 i_clk = ~i_clk;

    quaternion_trs_world_matrix_core DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_quat_x  (i_quat_x),
        .i_quat_y  (i_quat_y),
        .i_quat_z  (i_quat_z),
        .i_quat_w  (i_quat_w),
        .i_scale_x (i_scale_x),
        .i_scale_y (i_scale_y),
        .i_scale_z (i_scale_z),
        .i_trans_x (i_trans_x),
        .i_trans_y (i_trans_y),
        .i_trans_z (i_trans_z),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_m_r0_c0 (o_matrix[0]),
        .o_m_r0_c1 (o_matrix[1]),
        .o_m_r0_c2 (o_matrix[2]),
        .o_m_r1_c0 (o_matrix[3]),
        .o_m_r1_c1 (o_matrix[4]),
        .o_m_r1_c2 (o_matrix[5]),
        .o_m_r2_c0 (o_matrix[6]),
        .o_m_r2_c1 (o_matrix[7]),
        .o_m_r2_c2 (o_matrix[8]),
        .o_m_r3_c0 (o_matrix[9]),
        .o_m_r3_c1 (o_matrix[10]),
        .o_m_r3_c2 (o_matrix[11])
    );

    trs_matrix_checker u_matrix_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_in_stall       (o_stall),
        .i_quat_x         (i_quat_x),
        .i_quat_y         (i_quat_y),
        .i_quat_z         (i_quat_z),
        .i_quat_w         (i_quat_w),
        .i_scale_x        (i_scale_x),
        .i_scale_y        (i_scale_y),
        .i_scale_z        (i_scale_z),
        .i_trans_x        (i_trans_x),
        .i_trans_y        (i_trans_y),
        .i_trans_z        (i_trans_z),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_matrix         (o_matrix),
        .o_mismatch_count (mismatch_count),
        .o_matrices_due   (matrices_due)
    );

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic t_request pack_request(
        input int qx, input int qy, input int qz, input int qw,
        input int sx, input int sy, input int sz,
        input int tx, input int ty, input int tz
    );
        t_request r;
        r.qx = qx[QUAT_W-1:0];
        r.qy = qy[QUAT_W-1:0];
        r.qz = qz[QUAT_W-1:0];
        r.qw = qw[QUAT_W-1:0];
        r.sx = sx[SCALE_W-1:0];
        r.sy = sy[SCALE_W-1:0];
        r.sz = sz[SCALE_W-1:0];
        r.tx = tx;
        r.ty = ty;
        r.tz = tz;
        return r;
    endfunction

    function automatic logic [15:0] pick_short(input int unit);
        logic [15:0] v;
        case ($urandom_range(9))
            0: v = 16'h8000;
            1: v = 16'h7fff;
            2: v = 16'h0000;
            3: v = unit[15:0];
            4: v = -unit[15:0];
            5, 6: v = 16'($signed($urandom_range(2 * unit)) - unit);
            default: v = 16'($urandom());
        endcase
        return v;
    endfunction

    function automatic t_request random_request();
        t_request r;
        r.qx = pick_short(16384);
        r.qy = pick_short(16384);
        r.qz = pick_short(16384);
        r.qw = pick_short(16384);
        r.sx = pick_short(256);
        r.sy = pick_short(256);
        r.sz = pick_short(256);
        r.tx = $urandom();
        r.ty = $urandom();
        r.tz = $urandom();
        return r;
    endfunction

    task automatic send_request(input t_request r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_quat_x  <= r.qx;
        i_quat_y  <= r.qy;
        i_quat_z  <= r.qz;
        i_quat_w  <= r.qw;
        i_scale_x <= r.sx;
        i_scale_y <= r.sy;
        i_scale_z <= r.sz;
        i_trans_x <= r.tx;
        i_trans_y <= r.ty;
        i_trans_z <= r.tz;
        i_valid   <= 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (matrices_due != 0);
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_quat_x  <= '0;
        i_quat_y  <= '0;
        i_quat_z  <= '0;
        i_quat_w  <= '0;
        i_scale_x <= '0;
        i_scale_y <= '0;
        i_scale_z <= '0;
        i_trans_x <= '0;
        i_trans_y <= '0;
        i_trans_z <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(pack_request(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(pack_request(0, 0, 0, 16384, 256, 256, 256, 0, 0, 0));
        send_request(pack_request(0, 0, 0, 16384, -256, -256, -256, 65536, -65536, 1));
        send_request(pack_request(0, 0, 11585, 11585, 256, 256, 256, 100, 200, 300));
        send_request(pack_request(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        send_request(pack_request(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                                  32'h80000000, 32'h80000000, 32'h80000000));
        send_request(pack_request(-32768, -32768, -32768, -32768, 32767, 32767, 32767,
                                  0, 32'h7fffffff, 32'h80000000));
        send_request(pack_request(32767, -32768, 32767, -32768, -32768, 32767, -32768,
                                  32'h80000000, 0, 32'h7fffffff));
        send_request(pack_request(16384, 16384, 16384, 16384, 256, 256, 256, 0, 0, 0));
        send_request(pack_request(16'h5555, 16'h5555, 16'h5555, 16'h5555,
                                  16'haaaa, 16'haaaa, 16'haaaa,
                                  32'h55555555, 32'h55555555, 32'h55555555));
        send_request(pack_request(16'haaaa, 16'haaaa, 16'haaaa, 16'haaaa,
                                  16'h5555, 16'h5555, 16'h5555,
                                  32'haaaaaaaa, 32'haaaaaaaa, 32'haaaaaaaa));
        send_request(pack_request(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_request(pack_request(16384, 0, 0, 0, 1, -1, 128, 1, -1, 0));
        send_request(pack_request(0, -16384, 0, 3, 512, -512, 32767, -2, 2, 65535));
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            repeat (425) send_request(random_request());
            drain();
        end

        stall_pct = 0;
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #800000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
